>>> src/vrq_pkg.sv
// Shared types and constants for the virtual-runtime ready queue scheduler.
package vrq_pkg;

  localparam int unsigned ID_W = 8;
  localparam int unsigned VR_W = 63;
  localparam int unsigned PR_W = 2;
  localparam int unsigned SLICE_W = 4;
  localparam int unsigned TCNT_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned SLICE_BASE = 4;
  localparam int unsigned SLICE_MULT = 3;
  localparam logic [PR_W-1:0] PRIO_BOOST_MIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_VR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PR = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SCHEDULE = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [VR_W-1:0] vr;
    logic [PR_W-1:0] pr;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_POP,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t ent;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_REQUEUE
  } state_t;

  typedef struct packed {
    logic kind;
    logic [ID_W-1:0] task_id;
    logic [VR_W-1:0] task_vruntime;
    logic [PR_W-1:0] task_priority;
    logic [ID_W-1:0] current_id;
    logic [VR_W-1:0] current_vruntime;
    logic [PR_W-1:0] current_priority;
    logic current_running;
    logic [SLICE_W-1:0] slice_left;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] run_task_id;
    logic switched;
    logic [SLICE_W-1:0] new_slice;
    logic dropped;
    logic [TCNT_W-1:0] task_count;
  } out_item_t;

endpackage

>>> src/vrq_if.sv
// Valid/ready channel interfaces for the scheduler's item and result streams.
interface vrq_in_if;
  logic valid;
  logic ready;
  vrq_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface vrq_out_if;
  logic valid;
  logic ready;
  vrq_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> src/vrq_cell.sv
// One slot of the sorted shift-register queue.
module vrq_cell (
  input  logic               clk,
  input  vrq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               lt_left,
  input  vrq_pkg::entry_t    left_ent,
  input  vrq_pkg::entry_t    right_ent,
  output logic               lt_out,
  output vrq_pkg::entry_t    ent
);

  vrq_pkg::entry_t ent_r;
  vrq_pkg::entry_t ent_nxt;

  // Entries are sorted, so the cells that stay in place form a prefix.
  assign lt_out = occupied && (ent_r.vr < ctl.ent.vr);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      vrq_pkg::OP_POP: begin
        ent_nxt = right_ent;
      end
      vrq_pkg::OP_INSERT: begin
        if (lt_out) begin
          ent_nxt = ent_r;
        end else if (lt_left) begin
          ent_nxt = ctl.ent;
        end else begin
          ent_nxt = left_ent;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

>>> src/vruntime_ready_queue_scheduler.sv
// Top level: ready queue as a chain of cells, with the pop/requeue sequencer.
// Every item has an accept cycle (the pop of a schedule item shifts the cell
// chain) and an execute cycle (the insert or requeue shifts the chain again
// and loads the result register); the execute cycle waits while the result
// register is still held by the sink. A new item is accepted only after the
// last one has executed. Reset clears the count to one (empty queue), the
// idle-task registers and the handshake state; no clearing pass.
module vruntime_ready_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  vrq_in_if.sink                           in_ch,
  vrq_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [vrq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vrq_pkg::VR_W-1:0]         cfg_wdata
);

  // At least three bits, so the slice refill thresholds fit for small depths.
  localparam int unsigned CNT_W = ($clog2(QUEUE_DEPTH + 2) > 3) ?
                                  $clog2(QUEUE_DEPTH + 2) : 3;

  vrq_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, cnt_after, queue_len;
  logic [vrq_pkg::ID_W-1:0] idle_id_r;
  logic [vrq_pkg::VR_W-1:0] idle_vr_r;
  logic [vrq_pkg::PR_W-1:0] idle_pr_r;
  vrq_pkg::in_item_t item_r;
  vrq_pkg::entry_t head_r, head_now, ins_ent;
  vrq_pkg::out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic in_ready, exec, in_fire, pop_en, full, sw;
  logic ins_want, ins_do, drop;
  logic [2:0] quot;
  logic [CNT_W+vrq_pkg::TCNT_W-1:0] cnt_ext;
  vrq_pkg::cell_ctl_t ctl;

  vrq_pkg::entry_t cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_lt;
  logic [QUEUE_DEPTH-1:0] cell_occ;

  // ---------------- Configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_id_r <= '0;
      idle_vr_r <= '0;
      idle_pr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vrq_pkg::CFG_IDLE_ID: idle_id_r <= cfg_wdata[vrq_pkg::ID_W-1:0];
        vrq_pkg::CFG_IDLE_VR: idle_vr_r <= cfg_wdata;
        vrq_pkg::CFG_IDLE_PR: idle_pr_r <= cfg_wdata[vrq_pkg::PR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- Sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vrq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.item.kind == vrq_pkg::KIND_SCHEDULE) ?
                      vrq_pkg::ST_REQUEUE : vrq_pkg::ST_INSERT;
        end
      end
      vrq_pkg::ST_INSERT, vrq_pkg::ST_REQUEUE: begin
        if (exec) begin
          state_nxt = vrq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec = 1'b0;
    unique case (state_r)
      vrq_pkg::ST_IDLE: in_ready = 1'b1;
      vrq_pkg::ST_INSERT, vrq_pkg::ST_REQUEUE: exec = !out_valid_r || out_ch.ready;
      default: begin
        in_ready = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_fire = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrq_pkg::ST_IDLE;
      count_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- Pop in the accept cycle ----------------
  assign queue_len = count_r - CNT_W'(1);
  assign full = (count_r >= CNT_W'(QUEUE_DEPTH + 1));

  always_comb begin
    if (queue_len == '0) begin
      head_now.id = idle_id_r;
      head_now.vr = idle_vr_r;
      head_now.pr = idle_pr_r;
    end else begin
      head_now = cell_ent[0];
    end
  end

  assign pop_en = in_fire && (in_ch.item.kind == vrq_pkg::KIND_SCHEDULE) &&
                  (queue_len != '0);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_ch.item;
      head_r <= head_now;
    end
  end

  // ---------------- Insert or requeue in the execute cycle ----------------
  assign sw = (item_r.current_vruntime >= head_r.vr);

  always_comb begin
    ins_want = 1'b0;
    ins_ent.id = item_r.task_id;
    ins_ent.vr = item_r.task_vruntime;
    ins_ent.pr = item_r.task_priority;
    if (state_r == vrq_pkg::ST_INSERT) begin
      ins_want = 1'b1;
    end else if (state_r == vrq_pkg::ST_REQUEUE) begin
      if (sw) begin
        ins_want = item_r.current_running;
        ins_ent.id = item_r.current_id;
        ins_ent.vr = item_r.current_vruntime;
        ins_ent.pr = item_r.current_priority;
      end else begin
        ins_want = 1'b1;
        ins_ent = head_r;
      end
    end
  end

  // The idle task is never queued; a requeue after a pop always has room.
  assign ins_do = exec && ins_want && (ins_ent.id != idle_id_r) && !full;
  assign drop = (state_r == vrq_pkg::ST_INSERT) && (ins_ent.id != idle_id_r) && full;

  assign cnt_after = ins_do ? (count_r + CNT_W'(1)) : count_r;
  assign count_nxt = pop_en ? (count_r - CNT_W'(1)) : cnt_after;

  always_comb begin
    ctl.ent = ins_ent;
    if (pop_en) begin
      ctl.op = vrq_pkg::OP_POP;
    end else if (ins_do) begin
      ctl.op = vrq_pkg::OP_INSERT;
    end else begin
      ctl.op = vrq_pkg::OP_HOLD;
    end
  end

  // ---------------- Cell chain ----------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    vrq_pkg::entry_t left_ent, right_ent;
    logic lt_left;

    assign cell_occ[i] = (CNT_W'(i) < queue_len);

    if (i == 0) begin : g_first
      assign left_ent = ins_ent;
      assign lt_left = 1'b1;
    end else begin : g_inner
      assign left_ent = cell_ent[i-1];
      assign lt_left = cell_lt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = cell_ent[i];
    end else begin : g_mid
      assign right_ent = cell_ent[i+1];
    end

    vrq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (cell_occ[i]),
      .lt_left   (lt_left),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .lt_out    (cell_lt[i]),
      .ent       (cell_ent[i])
    );
  end

  // ---------------- Result ----------------
  // Integer 4/count for count >= 1: 4, 2, 1, 1, then 0.
  always_comb begin
    if (cnt_after == CNT_W'(1)) begin
      quot = 3'(vrq_pkg::SLICE_BASE);
    end else if (cnt_after == CNT_W'(2)) begin
      quot = 3'(vrq_pkg::SLICE_BASE / 2);
    end else if (cnt_after <= CNT_W'(vrq_pkg::SLICE_BASE)) begin
      quot = 3'd1;
    end else begin
      quot = 3'd0;
    end
  end

  assign cnt_ext = {{vrq_pkg::TCNT_W{1'b0}}, cnt_after};

  always_comb begin
    res_nxt.run_task_id = item_r.current_id;
    res_nxt.switched = 1'b0;
    res_nxt.new_slice = item_r.slice_left;
    res_nxt.dropped = drop;
    res_nxt.task_count = cnt_ext[vrq_pkg::TCNT_W-1:0];
    if (state_r == vrq_pkg::ST_REQUEUE) begin
      res_nxt.switched = sw;
      if (sw) begin
        res_nxt.run_task_id = head_r.id;
      end
      if (item_r.slice_left == '0) begin
        if (head_r.pr >= vrq_pkg::PRIO_BOOST_MIN) begin
          res_nxt.new_slice = vrq_pkg::SLICE_W'(quot) *
                              vrq_pkg::SLICE_W'(vrq_pkg::SLICE_MULT);
        end else begin
          res_nxt.new_slice = vrq_pkg::SLICE_W'(quot);
        end
      end
    end
  end

  assign out_valid_nxt = exec || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (exec) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item = res_r;

  // ---------------- Assertions ----------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_W'(QUEUE_DEPTH + 1)))
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_nxt == count_r) || (count_nxt == count_r + CNT_W'(1)) ||
    (count_nxt == count_r - CNT_W'(1)))
    else $error("queue count moved by more than one");

  a_sched_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.item.kind == vrq_pkg::KIND_SCHEDULE) |=>
    (state_r == vrq_pkg::ST_REQUEUE))
    else $error("schedule transaction did not enter requeue");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == vrq_pkg::ST_INSERT ||
                            $past(state_r) == vrq_pkg::ST_REQUEUE))
    else $error("result appeared without an execute cycle");

  a_no_pop_and_insert: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_en && ins_do))
    else $error("pop and insert in the same cycle");

endmodule

>>> verif/tb_vruntime_ready_queue_scheduler.sv
// Self-checking testbench for the virtual-runtime ready queue scheduler.
module tb_vruntime_ready_queue_scheduler;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 156;
  localparam logic [vrq_pkg::VR_W-1:0] VR_MAX = {vrq_pkg::VR_W{1'b1}};

  typedef struct {
    vrq_pkg::in_item_t  it;
    bit                 typed;
    vrq_pkg::out_item_t want;
  } probe_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vrq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vrq_pkg::VR_W-1:0] cfg_wdata;

  vrq_in_if  in_if();
  vrq_out_if out_if();

  vruntime_ready_queue_scheduler #(
    .QUEUE_DEPTH (DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the ready queue and idle-task registers.
  vrq_pkg::entry_t shadow_q[$];
  logic [vrq_pkg::ID_W-1:0] shadow_idle_id;
  logic [vrq_pkg::VR_W-1:0] shadow_idle_vr;
  logic [vrq_pkg::PR_W-1:0] shadow_idle_pr;

  vrq_pkg::out_item_t pending_results[$];
  probe_row_t probe_tbl[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit pace_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit shadow_insert(logic [vrq_pkg::ID_W-1:0] id,
                                       logic [vrq_pkg::VR_W-1:0] vr,
                                       logic [vrq_pkg::PR_W-1:0] pr);
    int pos;
    pos = 0;
    if (id == shadow_idle_id) return 1'b0;
    if (shadow_q.size() >= DEPTH) return 1'b1;
    // A new task goes ahead of entries with an equal runtime.
    while (pos < shadow_q.size() && shadow_q[pos].vr < vr) pos++;
    shadow_q.insert(pos, '{id: id, vr: vr, pr: pr});
    return 1'b0;
  endfunction

  function automatic vrq_pkg::out_item_t sched_outcome(vrq_pkg::in_item_t it);
    vrq_pkg::out_item_t r;
    vrq_pkg::entry_t head;
    int share;
    r.run_task_id = it.current_id;
    r.switched = 1'b0;
    r.new_slice = it.slice_left;
    r.dropped = 1'b0;
    if (it.kind == vrq_pkg::KIND_INSERT) begin
      r.dropped = shadow_insert(it.task_id, it.task_vruntime, it.task_priority);
    end else begin
      if (shadow_q.size() == 0)
        head = '{id: shadow_idle_id, vr: shadow_idle_vr, pr: shadow_idle_pr};
      else
        head = shadow_q.pop_front();
      if (it.current_vruntime >= head.vr) begin
        if (it.current_running)
          void'(shadow_insert(it.current_id, it.current_vruntime, it.current_priority));
        r.run_task_id = head.id;
        r.switched = 1'b1;
      end else begin
        void'(shadow_insert(head.id, head.vr, head.pr));
      end
      if (it.slice_left == '0) begin
        share = vrq_pkg::SLICE_BASE / (shadow_q.size() + 1);
        r.new_slice = (head.pr >= vrq_pkg::PRIO_BOOST_MIN) ?
                      vrq_pkg::SLICE_W'(share * vrq_pkg::SLICE_MULT) :
                      vrq_pkg::SLICE_W'(share);
      end
    end
    r.task_count = vrq_pkg::TCNT_W'(shadow_q.size() + 1);
    return r;
  endfunction

  function automatic logic [vrq_pkg::VR_W-1:0] rand_vr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[vrq_pkg::VR_W-1:0];
  endfunction

  function automatic logic [vrq_pkg::VR_W-1:0] pick_vr();
    logic [vrq_pkg::VR_W-1:0] base;
    base = (shadow_q.size() != 0) ? shadow_q[0].vr : shadow_idle_vr;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return VR_MAX;
      2, 3, 4: return vrq_pkg::VR_W'($urandom_range(0, 15));
      // Land on, just below or just above the head to hit the tie.
      5, 6: return base + vrq_pkg::VR_W'($urandom_range(0, 2)) - vrq_pkg::VR_W'(1);
      default: return rand_vr();
    endcase
  endfunction

  function automatic logic [vrq_pkg::ID_W-1:0] pick_id();
    return ($urandom_range(0, 15) == 0) ? shadow_idle_id : vrq_pkg::ID_W'($urandom);
  endfunction

  function automatic vrq_pkg::in_item_t gen_item(int unsigned ins_pct);
    vrq_pkg::in_item_t it;
    it.kind = ($urandom_range(0, 99) < ins_pct) ? vrq_pkg::KIND_INSERT
                                                : vrq_pkg::KIND_SCHEDULE;
    it.task_id = pick_id();
    it.task_vruntime = pick_vr();
    it.task_priority = vrq_pkg::PR_W'($urandom);
    it.current_id = pick_id();
    it.current_vruntime = pick_vr();
    it.current_priority = vrq_pkg::PR_W'($urandom);
    it.current_running = 1'($urandom);
    it.slice_left = ($urandom_range(0, 1) == 0) ? '0 : vrq_pkg::SLICE_W'($urandom);
    return it;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!pace_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic vrq_pkg::in_item_t mk_insert(logic [vrq_pkg::ID_W-1:0] id,
                                                  logic [vrq_pkg::VR_W-1:0] vr,
                                                  logic [vrq_pkg::PR_W-1:0] pr,
                                                  logic [vrq_pkg::ID_W-1:0] cur,
                                                  logic [vrq_pkg::SLICE_W-1:0] slice);
    vrq_pkg::in_item_t it;
    it = '0;
    it.kind = vrq_pkg::KIND_INSERT;
    it.task_id = id;
    it.task_vruntime = vr;
    it.task_priority = pr;
    it.current_id = cur;
    it.slice_left = slice;
    return it;
  endfunction

  function automatic vrq_pkg::in_item_t mk_sched(logic [vrq_pkg::ID_W-1:0] cur,
                                                 logic [vrq_pkg::VR_W-1:0] vr,
                                                 logic [vrq_pkg::PR_W-1:0] pr,
                                                 logic running,
                                                 logic [vrq_pkg::SLICE_W-1:0] slice);
    vrq_pkg::in_item_t it;
    it = '0;
    it.kind = vrq_pkg::KIND_SCHEDULE;
    it.current_id = cur;
    it.current_vruntime = vr;
    it.current_priority = pr;
    it.current_running = running;
    it.slice_left = slice;
    return it;
  endfunction

  function automatic void add_probe(vrq_pkg::in_item_t it, bit typed = 1'b0,
                                    vrq_pkg::out_item_t want = '0);
    probe_tbl.push_back('{it: it, typed: typed, want: want});
  endfunction

  // Holds the item until the block takes it, then records what it should produce.
  task automatic send_item(vrq_pkg::in_item_t it, bit typed = 1'b0,
                           vrq_pkg::out_item_t want = '0);
    int unsigned gap;
    vrq_pkg::out_item_t predicted;
    gap = gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.item <= it;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predicted = sched_outcome(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Upper data bits carry noise on the narrow registers; only the low bits count.
  task automatic load_idle(logic [vrq_pkg::ID_W-1:0] id, logic [vrq_pkg::VR_W-1:0] vr,
                           logic [vrq_pkg::PR_W-1:0] pr);
    logic [vrq_pkg::VR_W-1:0] noise;
    noise = rand_vr();
    cfg_we <= 1'b1;
    cfg_index <= vrq_pkg::CFG_IDLE_ID;
    cfg_wdata <= {noise[vrq_pkg::VR_W-1:vrq_pkg::ID_W], id};
    @(posedge clk);
    shadow_idle_id = id;
    cfg_index <= vrq_pkg::CFG_IDLE_VR;
    cfg_wdata <= vr;
    @(posedge clk);
    shadow_idle_vr = vr;
    cfg_index <= vrq_pkg::CFG_IDLE_PR;
    cfg_wdata <= {noise[vrq_pkg::VR_W-1:vrq_pkg::PR_W], pr};
    @(posedge clk);
    shadow_idle_pr = pr;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    vrq_pkg::out_item_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: %p", out_if.item);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("run_task_id", want.run_task_id, out_if.item.run_task_id);
        check_field("switched", want.switched, out_if.item.switched);
        check_field("new_slice", want.new_slice, out_if.item.new_slice);
        check_field("dropped", want.dropped, out_if.item.dropped);
        check_field("task_count", want.task_count, out_if.item.task_count);
      end
    end
  end

  // Result side back-pressure; a stall always drops ready, also when gap_len gives no gap.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pace_on && $urandom_range(0, 99) < 30) begin
        stall = 1 + gap_len();
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned ins_pct[PHASES] = '{80, 50, 35, 90, 45, 60, 30, 70};
    int unsigned counted;
    logic [vrq_pkg::ID_W-1:0] new_id;
    logic [vrq_pkg::VR_W-1:0] new_vr;
    logic [vrq_pkg::PR_W-1:0] new_pr;
    vrq_pkg::in_item_t it;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.item = '0;
    fail_count = 0;
    cycle_count = 0;
    pace_on = 1'b1;
    shadow_idle_id = '0;
    shadow_idle_vr = '0;
    shadow_idle_pr = '0;

    // Directed part, run with the idle task at its reset values.
    // An insert of the idle id is ignored and echoes the current task.
    add_probe(mk_insert(8'h00, VR_MAX, 2'd3, 8'hA5, 4'd15), 1'b1,
              '{8'hA5, 1'b0, 4'd15, 1'b0, 6'd1});
    // Empty queue: the idle task is switched to, the current one is not runnable.
    add_probe(mk_sched(8'hFF, '0, 2'd3, 1'b0, 4'd0), 1'b1,
              '{8'h00, 1'b1, 4'd4, 1'b0, 6'd1});
    // A nonzero slice above the nominal range passes through unchanged.
    add_probe(mk_sched(8'h07, VR_MAX, 2'd1, 1'b1, 4'd13), 1'b1,
              '{8'h00, 1'b1, 4'd13, 1'b0, 6'd2});
    add_probe(mk_insert(8'hFF, VR_MAX, 2'd3, 8'h00, 4'd0), 1'b1,
              '{8'h00, 1'b0, 4'd0, 1'b0, 6'd3});
    add_probe(mk_insert(8'h01, '0, 2'd2, 8'h5A, 4'd12));
    add_probe(mk_insert(8'h02, '0, 2'd1, 8'h5A, 4'd1));
    add_probe(mk_sched(8'h03, '0, 2'd0, 1'b1, 4'd0));
    add_probe(mk_sched(8'h10, '0, 2'd0, 1'b0, 4'd0));
    add_probe(mk_sched(8'h11, '0, 2'd3, 1'b1, 4'd0));
    add_probe(mk_insert(8'h20, 63'd5, 2'd0, 8'h33, 4'd7));
    add_probe(mk_sched(8'h30, '0, 2'd3, 1'b0, 4'd0));
    // Current runtime below the head's: the head goes back, current keeps running.
    add_probe(mk_sched(8'h31, 63'd4, 2'd1, 1'b1, 4'd0));
    add_probe(mk_sched(8'h32, 63'd5, 2'd2, 1'b1, 4'd0));
    // Requeue of a current task that carries the idle id is dropped silently.
    add_probe(mk_sched(8'h00, VR_MAX, 2'd1, 1'b1, 4'd0));
    add_probe(mk_sched(8'h40, '0, 2'd0, 1'b1, 4'd0));
    add_probe(mk_sched(8'h41, VR_MAX, 2'd3, 1'b1, 4'd0));
    add_probe(mk_sched(8'h42, VR_MAX, 2'd0, 1'b0, 4'd1));
    add_probe(mk_sched(8'h43, VR_MAX, 2'd0, 1'b0, 4'd0));
    add_probe(mk_sched(8'h44, 63'd1, 2'd2, 1'b1, 4'd0));
    add_probe(mk_insert(8'hAA, VR_MAX, 2'd3, 8'h55, 4'd15));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_tbl[i]) send_item(probe_tbl[i].it, probe_tbl[i].typed, probe_tbl[i].want);
    in_if.valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      new_id = vrq_pkg::ID_W'($urandom);
      new_vr = rand_vr();
      new_pr = vrq_pkg::PR_W'(p);
      case (p)
        0: begin new_id = 8'hFF; new_vr = VR_MAX; new_pr = 2'd3; end
        1: begin new_id = 8'h00; new_vr = '0; new_pr = 2'd0; end
        2, 6: new_vr = vrq_pkg::VR_W'($urandom_range(0, 15));
        4: begin new_id = 8'hFF; new_vr = '0; new_pr = 2'd3; end
        5: new_vr = VR_MAX;
        7: new_id = 8'h00;
        default: ;
      endcase
      // Sometimes make a task already queued become the idle task.
      if ((p == 2 || p == 5) && shadow_q.size() != 0)
        new_id = shadow_q[$urandom_range(0, shadow_q.size() - 1)].id;
      load_idle(new_id, new_vr, new_pr);

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (counted % 64 == 0) pace_on = ($urandom_range(0, 3) != 0);
        it = gen_item(ins_pct[p]);
        if (!(it.kind == vrq_pkg::KIND_INSERT && it.task_id == shadow_idle_id)) counted++;
        send_item(it);
      end
      in_if.valid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> vruntime_ready_queue_scheduler.f
src/vrq_pkg.sv
src/vrq_if.sv
src/vrq_cell.sv
src/vruntime_ready_queue_scheduler.sv
verif/tb_vruntime_ready_queue_scheduler.sv
